// ===== hw/rtl/ut2cal_pkg.sv =====
// Shared types, constants and tables for the Unix time to calendar converter.
`timescale 1ns / 1ps

package ut2cal_pkg;

  localparam int unsigned InWidth  = 31;
  localparam int unsigned QuotBits = 9;
  localparam int unsigned ShiftW   = 4;

  localparam logic [InWidth-1:0] Y2kSecs      = 31'd946684800;
  localparam logic [InWidth-1:0] LeapYearSecs = 31'(366 * 24 * 3600);
  localparam logic [InWidth-1:0] YearSecs     = 31'(365 * 24 * 3600);
  localparam logic [16:0]        DaySecs      = 17'd86400;
  localparam logic [16:0]        HourSecs     = 17'd3600;
  localparam logic [16:0]        MinSecs      = 17'd60;
  localparam logic [16:0]        WeekDays     = 17'd7;
  localparam logic [3:0]         LastMonth    = 4'd11;

  // Highest quotient bit of each division step sequence.
  localparam logic [ShiftW-1:0] DayTopBit  = 4'd8;
  localparam logic [ShiftW-1:0] HourTopBit = 4'd4;
  localparam logic [ShiftW-1:0] MinTopBit  = 4'd5;
  localparam logic [ShiftW-1:0] WeekTopBit = 4'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FLAG_BEFORE,
    OP_EPOCH,
    OP_YEAR,
    OP_DIV,
    OP_TAKE_DAY,
    OP_TAKE_HOUR,
    OP_TAKE_MIN,
    OP_MONTH,
    OP_TAKE_MONTH,
    OP_TAKE_WEEK,
    OP_PUBLISH
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } div_sel_e;

  typedef struct packed {
    dp_op_e              op;
    div_sel_e            div_sel;
    logic [ShiftW-1:0]   shift;
  } dp_cmd_t;

  typedef struct packed {
    logic lt_epoch;
    logic year_more;
    logic month_done;
  } dp_status_t;

  typedef struct packed {
    logic       before_epoch;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [2:0] day_in_week;
    logic [2:0] weeks_passed;
    logic [3:0] month;
    logic [5:0] year_offset;
  } result_t;

  function automatic logic [16:0] div_base(input div_sel_e sel);
    logic [16:0] base;
    unique case (sel)
      DIV_DAY:  base = DaySecs;
      DIV_HOUR: base = HourSecs;
      DIV_MIN:  base = MinSecs;
      DIV_WEEK: base = WeekDays;
      default:  base = WeekDays;
    endcase
    return base;
  endfunction

  // Month index is zero based.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:                       len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/ut2cal_dp.sv =====
// Datapath: working registers, shared compare/subtract unit and result register.
`timescale 1ns / 1ps

module ut2cal_dp (
  input  logic                                clk_i,
  input  ut2cal_pkg::dp_cmd_t                 cmd_i,
  input  logic [ut2cal_pkg::InWidth-1:0]      in_data_i,
  output ut2cal_pkg::dp_status_t              status_o,
  output ut2cal_pkg::result_t                 res_o
);

  import ut2cal_pkg::*;

  logic [InWidth-1:0]  rem_q;
  logic [5:0]          years_q;
  logic [3:0]          month_q;
  logic [QuotBits-1:0] day_q;
  logic [QuotBits-1:0] quot_q;
  logic [4:0]          hours_q;
  logic [5:0]          minutes_q;
  logic [5:0]          seconds_q;
  logic [2:0]          weeks_q;
  logic [2:0]          dow_q;
  logic                before_q;
  result_t             res_q;

  logic                leap;
  logic [InWidth-1:0]  year_len;
  logic [InWidth-1:0]  div_shifted;
  logic                div_ge;
  logic [4:0]          mlen;

  always_comb begin
    leap        = (years_q[1:0] == 2'd0);
    year_len    = leap ? LeapYearSecs : YearSecs;
    div_shifted = InWidth'(div_base(cmd_i.div_sel)) << cmd_i.shift;
    div_ge      = (rem_q >= div_shifted);
    mlen        = month_len(month_q, leap);

    status_o.lt_epoch   = (rem_q < Y2kSecs);
    status_o.year_more  = (rem_q >= year_len);
    status_o.month_done = (day_q < QuotBits'(mlen)) || (month_q == LastMonth);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        rem_q     <= in_data_i;
        years_q   <= '0;
        month_q   <= '0;
        day_q     <= '0;
        quot_q    <= '0;
        hours_q   <= '0;
        minutes_q <= '0;
        seconds_q <= '0;
        weeks_q   <= '0;
        dow_q     <= '0;
        before_q  <= 1'b0;
      end
      OP_FLAG_BEFORE: before_q <= 1'b1;
      OP_EPOCH:       rem_q <= rem_q - Y2kSecs;
      OP_YEAR: begin
        rem_q   <= rem_q - year_len;
        years_q <= years_q + 6'd1;
      end
      OP_DIV: begin
        if (div_ge) begin
          rem_q                 <= rem_q - div_shifted;
          quot_q[cmd_i.shift] <= 1'b1;
        end
      end
      OP_TAKE_DAY: begin
        day_q  <= quot_q;
        quot_q <= '0;
      end
      OP_TAKE_HOUR: begin
        hours_q <= quot_q[4:0];
        quot_q  <= '0;
      end
      OP_TAKE_MIN: begin
        minutes_q <= quot_q[5:0];
        seconds_q <= rem_q[5:0];
        quot_q    <= '0;
      end
      OP_MONTH: begin
        day_q   <= day_q - QuotBits'(mlen);
        month_q <= month_q + 4'd1;
      end
      OP_TAKE_MONTH: rem_q <= InWidth'(day_q);
      OP_TAKE_WEEK: begin
        weeks_q <= quot_q[2:0];
        dow_q   <= rem_q[2:0] + 3'd1;
      end
      OP_PUBLISH: begin
        res_q.year_offset  <= years_q;
        res_q.month        <= before_q ? 4'd0 : month_q + 4'd1;
        res_q.weeks_passed <= weeks_q;
        res_q.day_in_week  <= dow_q;
        res_q.hours        <= hours_q;
        res_q.minutes      <= minutes_q;
        res_q.seconds      <= seconds_q;
        res_q.before_epoch <= before_q;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/ut2cal_ctrl.sv =====
// Controller: sequences the datapath and runs the stream handshakes.
`timescale 1ns / 1ps

module ut2cal_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  output logic                    s_ready_o,
  output logic                    m_valid_o,
  input  logic                    m_ready_i,
  input  ut2cal_pkg::dp_status_t  status_i,
  output ut2cal_pkg::dp_cmd_t     cmd_o
);

  import ut2cal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EPOCH,
    S_YEAR,
    S_DDAY,
    S_TDAY,
    S_DHOUR,
    S_THOUR,
    S_DMIN,
    S_TMIN,
    S_MONTH,
    S_TMONTH,
    S_DWEEK,
    S_TWEEK,
    S_PUB
  } state_e;

  state_e            state_q, state_d;
  logic [ShiftW-1:0] count_q, count_d;
  logic              m_valid_q, m_valid_d;
  logic              can_pub;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    cmd_o.op      = OP_NONE;
    cmd_o.div_sel = DIV_DAY;
    cmd_o.shift   = count_q;
    can_pub       = !m_valid_q || m_ready_i;
    m_valid_d     = m_valid_q && !m_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_EPOCH;
        end
      end
      S_EPOCH: begin
        if (status_i.lt_epoch) begin
          cmd_o.op = OP_FLAG_BEFORE;
          state_d  = S_PUB;
        end else begin
          cmd_o.op = OP_EPOCH;
          state_d  = S_YEAR;
        end
      end
      S_YEAR: begin
        if (status_i.year_more) begin
          cmd_o.op = OP_YEAR;
        end else begin
          state_d = S_DDAY;
          count_d = DayTopBit;
        end
      end
      S_DDAY: begin
        cmd_o.op      = OP_DIV;
        cmd_o.div_sel = DIV_DAY;
        if (count_q == '0) state_d = S_TDAY;
        else count_d = count_q - 1'b1;
      end
      S_TDAY: begin
        cmd_o.op = OP_TAKE_DAY;
        state_d  = S_DHOUR;
        count_d  = HourTopBit;
      end
      S_DHOUR: begin
        cmd_o.op      = OP_DIV;
        cmd_o.div_sel = DIV_HOUR;
        if (count_q == '0) state_d = S_THOUR;
        else count_d = count_q - 1'b1;
      end
      S_THOUR: begin
        cmd_o.op = OP_TAKE_HOUR;
        state_d  = S_DMIN;
        count_d  = MinTopBit;
      end
      S_DMIN: begin
        cmd_o.op      = OP_DIV;
        cmd_o.div_sel = DIV_MIN;
        if (count_q == '0) state_d = S_TMIN;
        else count_d = count_q - 1'b1;
      end
      S_TMIN: begin
        cmd_o.op = OP_TAKE_MIN;
        state_d  = S_MONTH;
      end
      S_MONTH: begin
        if (status_i.month_done) state_d = S_TMONTH;
        else cmd_o.op = OP_MONTH;
      end
      S_TMONTH: begin
        cmd_o.op = OP_TAKE_MONTH;
        state_d  = S_DWEEK;
        count_d  = WeekTopBit;
      end
      S_DWEEK: begin
        cmd_o.op      = OP_DIV;
        cmd_o.div_sel = DIV_WEEK;
        if (count_q == '0) state_d = S_TWEEK;
        else count_d = count_q - 1'b1;
      end
      S_TWEEK: begin
        cmd_o.op = OP_TAKE_WEEK;
        state_d  = S_PUB;
      end
      S_PUB: begin
        if (can_pub) begin
          cmd_o.op  = OP_PUBLISH;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

// ===== hw/rtl/unix_time_to_calendar.sv =====
// Top level of the Unix time to calendar converter.
`timescale 1ns / 1ps

// Converts a 31-bit Unix time in seconds to calendar fields counted from
// 2000-01-01 (leap rule exact for 2000..2099). One transfer in gives one
// transfer out. Work runs on a single shared compare/subtract unit, one
// step per cycle unless the publish step waits on a full output register:
// load and epoch check, one step per whole year (up to 38) plus one to
// leave the year loop, 9 + 5 + 6 + 3 restoring division steps for day,
// hour, minute and week, one step per whole month (up to 11) plus one to
// leave the month loop, plus 6 transfer/publish steps. Inputs before 2000
// go from the epoch check straight to publish, with tuser set and all
// tdata fields zero. The result sits in an output register, so a new input
// is taken while the previous result still waits.
module unix_time_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] year_offset, [9:6] month, [12:10] weeks_passed, [15:13] day_in_week,
  // [20:16] hours, [26:21] minutes, [32:27] seconds, [39:33] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] before_epoch
);

  import ut2cal_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    res;

  ut2cal_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ut2cal_dp u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata[InWidth-1:0]),
    .status_o  (status),
    .res_o     (res)
  );

  assign m_axis_tdata = {7'd0, res.seconds, res.minutes, res.hours, res.day_in_week,
                         res.weeks_passed, res.month, res.year_offset};
  assign m_axis_tuser = res.before_epoch;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Unix time to calendar converter.
`timescale 1ns / 1ps

module tb;
  import ut2cal_pkg::*;

  localparam int unsigned EPOCH_2000   = 946684800;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned LATEST_SECS  = 32'h7FFF_FFFF;
  localparam int unsigned ITEMS_PER_PHASE = 450;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [31:0] word;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  result_t     cal_expected_q [$];
  stim_row_t   dir_tab [22];
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_reqs;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned early_count;
  int unsigned results_checked;

  unix_time_to_calendar dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic int unsigned days_in(int unsigned mo, bit leap);
    return MONTH_DAYS[mo] + ((mo == 1 && leap) ? 1 : 0);
  endfunction

  function automatic result_t cal(bit be, int unsigned yr, int unsigned mon, int unsigned wk,
                                  int unsigned dw, int unsigned hh, int unsigned mm,
                                  int unsigned ss);
    result_t r;
    r.before_epoch = be;
    r.year_offset  = yr[5:0];
    r.month        = mon[3:0];
    r.weeks_passed = wk[2:0];
    r.day_in_week  = dw[2:0];
    r.hours        = hh[4:0];
    r.minutes      = mm[5:0];
    r.seconds      = ss[5:0];
    return r;
  endfunction

  // Calendar fields of a timestamp; years past 2000 peeled off one at a time.
  function automatic result_t calendar_of(logic [31:0] word);
    int unsigned t, yr, mo, day, sod, len;
    bit leap;
    t = {1'b0, word[30:0]};
    if (t < EPOCH_2000) return cal(1'b1, 0, 0, 0, 0, 0, 0, 0);
    t  = t - EPOCH_2000;
    yr = 0;
    len = 366 * SECS_PER_DAY;
    while (t >= len) begin
      t  = t - len;
      yr = yr + 1;
      len = (yr % 4 == 0) ? 366 * SECS_PER_DAY : 365 * SECS_PER_DAY;
    end
    leap = (yr % 4 == 0);
    day = t / SECS_PER_DAY;
    sod = t % SECS_PER_DAY;
    mo  = 0;
    len = days_in(mo, leap);
    while (mo < 11 && day >= len) begin
      day = day - len;
      mo  = mo + 1;
      len = days_in(mo, leap);
    end
    return cal(1'b0, yr, mo + 1, day / 7, day % 7 + 1, sod / 3600, (sod % 3600) / 60,
               sod % 60);
  endfunction

  function automatic longint unsigned seconds_at(int unsigned yr, int unsigned mo,
                                                 int unsigned dom);
    longint unsigned days;
    days = 0;
    for (int unsigned y = 0; y < yr; y++) days += (y % 4 == 0) ? 366 : 365;
    for (int unsigned m = 0; m < mo; m++) days += days_in(m, yr % 4 == 0);
    days += dom;
    return EPOCH_2000 + days * SECS_PER_DAY;
  endfunction

  // Mix of raw words, pre-2000 values, uniform post-2000 values and instants
  // on the first, last or a random day of a month, often close to midnight.
  function automatic logic [31:0] random_timestamp();
    int unsigned pick, yr, mo, dom, sod, roll;
    longint unsigned secs;
    logic [31:0] word;
    pick = $urandom_range(99);
    if (pick < 15) begin
      word = $urandom();
    end else if (pick < 25) begin
      word = $urandom_range(EPOCH_2000 - 1, 0);
    end else if (pick < 60) begin
      word = $urandom_range(LATEST_SECS, EPOCH_2000);
    end else begin
      yr  = $urandom_range(38);
      mo  = $urandom_range(11);
      roll = $urandom_range(2);
      if (roll == 0) dom = 0;
      else if (roll == 1) dom = days_in(mo, yr % 4 == 0) - 1;
      else dom = $urandom_range(days_in(mo, yr % 4 == 0) - 1);
      roll = $urandom_range(2);
      if (roll == 0) sod = $urandom_range(2);
      else if (roll == 1) sod = SECS_PER_DAY - 1 - $urandom_range(2);
      else sod = $urandom_range(SECS_PER_DAY - 1);
      secs = seconds_at(yr, mo, dom) + sod;
      if (secs > LATEST_SECS) secs = LATEST_SECS - $urandom_range(3);
      word = secs[31:0];
    end
    word[31] = 1'($urandom_range(1));
    return word;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic send_item(input logic [31:0] word, input bit typed, input result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cal_expected_q.push_back(typed ? want : calendar_of(word));
    items_sent++;
    if (word[30:0] < EPOCH_2000) early_count++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (cal_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               cal_expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sink side: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned holds_done;
    holds_done    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end
      m_axis_tready = rst_ni && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cal_expected_q.size() == 0) begin
        $error("result transfer with no timestamp pending");
        fail_count++;
      end else begin
        want = cal_expected_q.pop_front();
        results_checked++;
        check_field("year_offset", want.year_offset, m_axis_tdata[5:0]);
        check_field("month", want.month, m_axis_tdata[9:6]);
        check_field("weeks_passed", want.weeks_passed, m_axis_tdata[12:10]);
        check_field("day_in_week", want.day_in_week, m_axis_tdata[15:13]);
        check_field("hours", want.hours, m_axis_tdata[20:16]);
        check_field("minutes", want.minutes, m_axis_tdata[26:21]);
        check_field("seconds", want.seconds, m_axis_tdata[32:27]);
        check_field("tdata padding", 0, m_axis_tdata[39:33]);
        check_field("before_epoch", want.before_epoch, m_axis_tuser);
      end
    end
  end

  initial begin
    result_t none;
    none = '0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_reqs      = 0;
    fail_count     = 0;
    cycle_count    = 0;
    items_sent     = 0;
    early_count    = 0;
    results_checked = 0;

    dir_tab = '{
      '{32'd0,                          1'b1, cal(1, 0, 0, 0, 0, 0, 0, 0)},
      '{32'd946684799,                  1'b1, cal(1, 0, 0, 0, 0, 0, 0, 0)},
      '{32'h8000_0000,                  1'b1, cal(1, 0, 0, 0, 0, 0, 0, 0)},
      '{32'd946684800,                  1'b1, cal(0, 0, 1, 0, 1, 0, 0, 0)},
      '{32'h8000_0000 | 32'd946684800,  1'b1, cal(0, 0, 1, 0, 1, 0, 0, 0)},
      '{32'h7FFF_FFFF,                  1'b1, cal(0, 38, 1, 2, 5, 3, 14, 7)},
      '{32'hFFFF_FFFF,                  1'b1, cal(0, 38, 1, 2, 5, 3, 14, 7)},
      '{32'd978307200,                  1'b1, cal(0, 1, 1, 0, 1, 0, 0, 0)},
      '{32'd978307199,                  1'b0, none},
      '{32'd949363199,                  1'b0, none},
      '{32'd949363200,                  1'b0, none},
      '{32'd951782399,                  1'b0, none},
      '{32'd951782400,                  1'b0, none},
      '{32'd951868800,                  1'b0, none},
      '{32'd983404799,                  1'b0, none},
      '{32'd983404800,                  1'b0, none},
      '{32'd1078012800,                 1'b0, none},
      '{32'd2145916799,                 1'b0, none},
      '{32'd2145916800,                 1'b0, none},
      '{32'd946771199,                  1'b0, none},
      '{32'h5555_5555,                  1'b0, none},
      '{32'hAAAA_AAAA,                  1'b0, none}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
        default: begin src_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      repeat (ITEMS_PER_PHASE) send_item(random_timestamp(), 1'b0, none);
      drain();
      if (phase == 1) begin
        // Sink holds off while the source keeps pushing, so the input backs up.
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_reqs++;
        repeat (16) send_item(random_timestamp(), 1'b0, none);
        drain();
      end
    end

    $display("Converted %0d timestamps (%0d before 2000), %0d results checked", items_sent,
             early_count, results_checked);
    $display("Covered year, month and leap-day boundaries under four idle patterns and a long hold");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
